### sv/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// shared constants, widths and exp tables for the softmax normalizer
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int MAX_ELEMENTS = 8;
  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int SUM_W = 17 + $clog2(MAX_ELEMENTS);
  localparam int NUM_W = 33;
  localparam int QCNT_W = $clog2(NUM_W + 1);

  localparam logic [7:0] EXP_IP_LIMIT = 8'd12;

  // round(65536 * e^-ip)
  function automatic logic [16:0] exp_int(input logic [3:0] ip);
    logic [16:0] v;
    unique case (ip)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // round(65536 * e^-(hi/16))
  function automatic logic [16:0] exp_frac(input logic [3:0] hi);
    logic [16:0] v;
    unique case (hi)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd61565;
      4'd2:  v = 17'd57835;
      4'd3:  v = 17'd54331;
      4'd4:  v = 17'd51039;
      4'd5:  v = 17'd47947;
      4'd6:  v = 17'd45042;
      4'd7:  v = 17'd42313;
      4'd8:  v = 17'd39750;
      4'd9:  v = 17'd37341;
      4'd10: v = 17'd35079;
      4'd11: v = 17'd32954;
      4'd12: v = 17'd30957;
      4'd13: v = 17'd29081;
      4'd14: v = 17'd27319;
      4'd15: v = 17'd25664;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

### sv/smx_in_if.sv
// ----------------------------------------------------------------------------
// smx_in_if
// score channel: one signed q8.8 score per item with a last flag
// ----------------------------------------------------------------------------
interface smx_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] score;
  logic               last_element;

  modport source (output valid, output score, output last_element, input ready);
  modport sink   (input valid, input score, input last_element, output ready);
endinterface

### sv/smx_out_if.sv
// ----------------------------------------------------------------------------
// smx_out_if
// probability channel: one unsigned q0.16 probability per item
// ----------------------------------------------------------------------------
interface smx_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] probability;
  logic        last_result;
  logic        overflowed;

  modport source (output valid, output probability, output last_result,
                  output overflowed, input ready);
  modport sink   (input valid, input probability, input last_result,
                  input overflowed, output ready);
endinterface

### sv/softmax_normalizer_unit.sv
// ----------------------------------------------------------------------------
// softmax_normalizer_unit
// max-subtracted softmax over a short vector of q8.8 scores, one shared
// multiplier for the exp approximation and a bit-serial divider
// ----------------------------------------------------------------------------
//  channel  dir  payload                                    item
//  scores   in   score[15:0] s q8.8, last_element           one element
//  probs    out  probability[15:0] q0.16, last_result, ovf  one probability
//
//  a score is taken while the block is in S_LOAD; after the last one the
//  block computes exp per stored element in S_X, S_RR, S_AB, S_TC and S_W
//  (shared 17x17 multiplier), then per element S_DINIT, the bit-serial
//  S_DSTEP divider steps and S_OUT; scores.ready is low from the last
//  element until the final probability is taken; output stalls simply
//  hold the result register; rst is synchronous and clears count, max, sum and overflow flag
// ----------------------------------------------------------------------------
module softmax_normalizer_unit (
  input  logic      clk,
  input  logic      rst,
  smx_in_if.sink    scores,
  smx_out_if.source probs
);
  import smx_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_X, S_RR, S_AB, S_TC, S_W, S_DINIT, S_DSTEP, S_OUT
  } state_t;

  state_t state;

  logic signed [15:0] score_store [MAX_ELEMENTS];
  logic [16:0]        weight_store [MAX_ELEMENTS];
  logic [CNT_W-1:0]   element_count;
  logic signed [15:0] running_max;
  logic [SUM_W-1:0]   weight_sum;
  logic               overflow_flag;

  logic [IDX_W-1:0]   idx;
  logic [3:0]         ip, hi, lo;
  logic               exp_zero;
  logic [16:0]        c_coef;
  logic [33:0]        prod;
  logic [NUM_W-1:0]   num, quo;
  logic [SUM_W-1:0]   rem;
  logic [QCNT_W-1:0]  qcnt;

  // shared multiplier
  logic [16:0] mul_a, mul_b;
  logic [33:0] mul_p;
  logic [11:0] r_val;
  logic [34:0] prod_rnd;
  logic [16:0] prod_q16;
  logic signed [16:0] diff;
  logic [SUM_W:0] rem_sh;
  logic        rem_ge;
  logic        idx_at_end;
  logic        accept, store_ok;
  logic [16:0] w_cur;

  assign r_val    = {lo, 8'd0};
  assign prod_rnd = {1'b0, prod} + 35'd32768;
  assign prod_q16 = prod_rnd[32:16];
  assign diff     = 17'(running_max) - 17'(score_store[idx]);
  assign w_cur    = exp_zero ? 17'd0 : prod_q16;
  assign rem_sh   = {rem, num[NUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, weight_sum};
  assign idx_at_end = (CNT_W'(idx) + CNT_W'(1)) == element_count;
  assign accept   = scores.valid && scores.ready;
  assign store_ok = element_count < CNT_W'(MAX_ELEMENTS);

  always_comb begin
    unique case (state)
      S_RR: begin
        mul_a = 17'(r_val);
        mul_b = 17'(r_val);
      end
      S_AB: begin
        mul_a = exp_int(ip);
        mul_b = exp_frac(hi);
      end
      S_TC: begin
        mul_a = prod_q16;
        mul_b = c_coef;
      end
      default: begin
        mul_a = 17'd0;
        mul_b = 17'd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign scores.ready = (state == S_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      element_count <= '0;
      running_max   <= 16'sh8000;
      weight_sum    <= '0;
      overflow_flag <= 1'b0;
      idx           <= '0;
      probs.valid   <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (store_ok) begin
              score_store[element_count[IDX_W-1:0]] <= scores.score;
              element_count <= element_count + CNT_W'(1);
              if (scores.score > running_max) running_max <= scores.score;
            end else begin
              overflow_flag <= 1'b1;
            end
            if (scores.last_element) begin
              idx        <= '0;
              weight_sum <= '0;
              state      <= S_X;
            end
          end
        end
        S_X: begin
          ip       <= diff[11:8];
          hi       <= diff[7:4];
          lo       <= diff[3:0];
          exp_zero <= diff[15:8] >= EXP_IP_LIMIT;
          state    <= S_RR;
        end
        S_RR: begin
          prod  <= mul_p;
          state <= S_AB;
        end
        S_AB: begin
          c_coef <= 17'd65536 - 17'(r_val) + 17'(prod[33:17]);
          prod   <= mul_p;
          state  <= S_TC;
        end
        S_TC: begin
          prod  <= mul_p;
          state <= S_W;
        end
        S_W: begin
          weight_store[idx] <= w_cur;
          weight_sum        <= weight_sum + SUM_W'(w_cur);
          if (idx_at_end) begin
            idx   <= '0;
            state <= S_DINIT;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_X;
          end
        end
        S_DINIT: begin
          num   <= {weight_store[idx], 16'd0} + NUM_W'(weight_sum >> 1);
          rem   <= '0;
          quo   <= '0;
          qcnt  <= '0;
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          rem  <= rem_ge ? SUM_W'(rem_sh - {1'b0, weight_sum}) : rem_sh[SUM_W-1:0];
          quo  <= {quo[NUM_W-2:0], rem_ge};
          num  <= {num[NUM_W-2:0], 1'b0};
          qcnt <= qcnt + QCNT_W'(1);
          if (qcnt == QCNT_W'(NUM_W - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (!probs.valid) begin
            probs.valid       <= 1'b1;
            probs.last_result <= idx_at_end;
            probs.overflowed  <= overflow_flag;
            if (weight_sum == '0)       probs.probability <= 16'd0;
            else if (quo[NUM_W-1:16] != '0) probs.probability <= 16'hFFFF;
            else                        probs.probability <= quo[15:0];
          end else if (probs.ready) begin
            probs.valid <= 1'b0;
            if (idx_at_end) begin
              element_count <= '0;
              running_max   <= 16'sh8000;
              weight_sum    <= '0;
              overflow_flag <= 1'b0;
              idx           <= '0;
              state         <= S_LOAD;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_DINIT;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    element_count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count beyond capacity");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(scores.ready && probs.valid))
    else $error("scores taken while a probability is pending");
  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    probs.valid && probs.ready && probs.last_result |=>
      element_count == '0 && !overflow_flag && scores.ready)
    else $error("state not cleared after final probability");
  a_last_once: assert property (@(posedge clk) disable iff (rst)
    probs.valid && probs.last_result |-> idx_at_end)
    else $error("last flag on an inner probability");
`endif

endmodule

### bench/softmax_checker.sv
// ----------------------------------------------------------------------------
// softmax_checker
// watches the score and probability channels, predicts each vector's
// probabilities from the accepted scores and compares every result field
// ----------------------------------------------------------------------------
module softmax_checker (
  input  logic      clk,
  input  logic      rst,
  smx_in_if         scores,
  smx_out_if        probs,
  output int        fail_count,
  output int        pending_probs,
  output int        results_seen
);
  import smx_pkg::*;

  typedef struct packed {
    logic [15:0] probability;
    logic        last_result;
    logic        overflowed;
  } prob_t;

  prob_t               prob_queue[$];
  logic signed [15:0]  vec_scores[MAX_ELEMENTS];
  int                  vec_count;
  logic signed [15:0]  vec_max;
  logic                vec_dropped;

  function automatic logic [16:0] exp_weight(input logic [16:0] x);
    logic [7:0]  ip;
    logic [3:0]  hi;
    logic [31:0] r;
    logic [63:0] c, t, w;
    ip = x[15:8];
    hi = x[7:4];
    r = 32'(x[3:0]) * 256;
    if (x[16] || ip >= EXP_IP_LIMIT) return 17'd0;
    c = 64'(65536 - r + ((r * r) >> 17));
    t = (64'(exp_int(ip[3:0])) * 64'(exp_frac(hi)) + 64'd32768) >> 16;
    w = (t * c + 64'd32768) >> 16;
    return w[16:0];
  endfunction

  task automatic predict_vector();
    logic [16:0] wts[MAX_ELEMENTS];
    logic [31:0] sum;
    logic [63:0] p;
    prob_t       e;
    sum = 0;
    for (int i = 0; i < vec_count; i++) begin
      wts[i] = exp_weight(17'(32'(vec_max) - 32'(vec_scores[i])));
      sum += wts[i];
    end
    for (int i = 0; i < vec_count; i++) begin
      p = 0;
      if (sum != 0) begin
        p = (64'(wts[i]) * 65536 + 64'(sum >> 1)) / 64'(sum);
        if (p > 65535) p = 65535;
      end
      e.probability = p[15:0];
      e.last_result = (i + 1 == vec_count);
      e.overflowed = vec_dropped;
      prob_queue.push_back(e);
    end
    vec_count = 0;
    vec_max = -16'sd32768;
    vec_dropped = 0;
  endtask

  assign pending_probs = prob_queue.size();

  always @(posedge clk) begin
    prob_t e;
    if (rst) begin
      vec_count = 0;
      vec_max = -16'sd32768;
      vec_dropped = 0;
      fail_count = 0;
      results_seen = 0;
      prob_queue.delete();
    end else begin
      if (probs.valid && probs.ready) begin
        results_seen++;
        if (prob_queue.size() == 0) begin
          $error("unexpected probability %0d", probs.probability);
          fail_count++;
        end else begin
          e = prob_queue.pop_front();
          if (probs.probability !== e.probability) begin
            $error("probability expected %0d actual %0d", e.probability, probs.probability);
            fail_count++;
          end
          if (probs.last_result !== e.last_result) begin
            $error("last_result expected %0d actual %0d", e.last_result, probs.last_result);
            fail_count++;
          end
          if (probs.overflowed !== e.overflowed) begin
            $error("overflowed expected %0d actual %0d", e.overflowed, probs.overflowed);
            fail_count++;
          end
        end
      end
      if (scores.valid && scores.ready) begin
        if (vec_count < MAX_ELEMENTS) begin
          vec_scores[vec_count] = scores.score;
          vec_count++;
          if (scores.score > vec_max) vec_max = scores.score;
        end else begin
          vec_dropped = 1;
        end
        if (scores.last_element) predict_vector();
      end
    end
  end
endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives score vectors into the softmax normalizer, mostly under random idling on
// both channels; the checker predicts and compares every probability
// ----------------------------------------------------------------------------
module testbench;
  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending_probs, results_seen;
  int   send_idle = 0, recv_idle = 0;
  int   vectors_sent = 0, overflow_vectors = 0;

  smx_in_if  scores();
  smx_out_if probs();

  softmax_normalizer_unit uut (.clk(clk), .rst(rst), .scores(scores), .probs(probs));

  softmax_checker chk (
    .clk(clk), .rst(rst), .scores(scores), .probs(probs),
    .fail_count(fail_count), .pending_probs(pending_probs), .results_seen(results_seen)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    scores.valid = 0;
    scores.score = 0;
    scores.last_element = 0;
    probs.ready = 0;
  end

  always @(posedge clk) begin
    if (rst) probs.ready <= 0;
    else probs.ready <= ($urandom_range(99) >= recv_idle);
  end

  // valid stays high from one item to the next unless the sender idles
  task automatic send_score(input logic signed [15:0] s, input logic lst);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      scores.valid <= 0;
      @(posedge clk);
    end
    scores.valid <= 1;
    scores.score <= s;
    scores.last_element <= lst;
    do @(posedge clk); while (!scores.ready);
  endtask

  task automatic send_vector(input logic signed [15:0] v[$]);
    for (int i = 0; i < v.size(); i++) send_score(v[i], i == v.size() - 1);
    vectors_sent++;
    if (v.size() > smx_pkg::MAX_ELEMENTS) overflow_vectors++;
  endtask

  function automatic logic signed [15:0] near_score(input logic signed [15:0] base);
    int d;
    d = $urandom_range(1, 0) ? int'($urandom_range(3072)) : int'($urandom_range(65535));
    return 16'(int'(base) - d);
  endfunction

  task automatic random_vectors(input int items);
    logic signed [15:0] v[$];
    logic signed [15:0] base;
    int n, sent;
    sent = 0;
    while (sent < items) begin
      v.delete();
      n = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 1);
      base = 16'($urandom);
      for (int i = 0; i < n; i++)
        v.push_back($urandom_range(3) == 0 ? 16'($urandom) : near_score(base));
      send_vector(v);
      sent += n;
    end
  endtask

  initial begin
    logic signed [15:0] v[$];
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_idle = 30; recv_idle = 87;
    v = '{16'sh7fff};                       send_vector(v);
    v = '{-16'sd32768, 16'sh7fff};          send_vector(v);
    v = '{16'sh0000, 16'sh0000, 16'sh0000}; send_vector(v);
    v = '{16'sh0100, 16'sh0000, -16'sh0b00, -16'sh0c00, 16'sh00ff, 16'sh55aa};
    send_vector(v);
    v = '{16'sh1234, -16'sd2, 16'sh0f0f, 16'sh0, 16'sh7ffe, -16'sd32767, 16'sh2000,
          16'sh7fff, 16'sh1111, -16'sd1};
    send_vector(v);
    scores.valid <= 0;
    wait (pending_probs == 0);
    repeat (400) @(posedge clk);
    random_vectors(46);
    send_idle = 87; recv_idle = 30;
    random_vectors(46);
    send_idle = 0; recv_idle = 0;
    random_vectors(46);
    scores.valid <= 0;
    wait (pending_probs == 0);
    repeat (400) @(posedge clk);
    $display("sent %0d vectors (%0d over capacity), checked %0d probabilities",
             vectors_sent, overflow_vectors, results_seen);
    if (fail_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #40000000;
    $display("testbench failed");
    $finish;
  end
endmodule
